// ===== hw/rtl/sonar_sweep_intrusion_detector_macros.svh =====
// Assertion macros shared by the sonar sweep intrusion detector RTL.
// No dependencies; included by the modules that carry checks.
`ifndef SONAR_SWEEP_INTRUSION_DETECTOR_MACROS_SVH
`define SONAR_SWEEP_INTRUSION_DETECTOR_MACROS_SVH

// cause in one cycle requires effect in the same cycle
`define SSID_ASSERT_SAME(label, clk, rst, cause, effect) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
      else $error("ssid assertion failed");

// cause in one cycle requires effect in the next cycle
`define SSID_ASSERT_NEXT(label, clk, rst, cause, effect) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error("ssid assertion failed");

`endif

// ===== hw/rtl/ssid_pkg.sv =====
// Package for the sonar sweep intrusion detector: codes, reset values and
// the structs passed between the top level, the cells and the output queue.
`timescale 1ns / 1ps

package ssid_pkg;

   localparam int POINTS_DEFAULT         = 64;
   localparam int SWEEP_MIN_DEG_DEFAULT  = 26;
   localparam int SWEEP_STEP_DEG_DEFAULT = 2;

   localparam logic [1:0] FUNC_ADVANCE = 2'd0;
   localparam logic [1:0] FUNC_RECORD  = 2'd1;
   localparam logic [1:0] FUNC_SAVE    = 2'd2;
   localparam logic [1:0] FUNC_CHECK   = 2'd3;

   localparam logic [1:0] MODE_OFF      = 2'd0;
   localparam logic [1:0] MODE_SCAN     = 2'd1;
   localparam logic [1:0] MODE_SENTINEL = 2'd2;

   localparam logic [1:0] CSR_MODE      = 2'd0;
   localparam logic [1:0] CSR_RANGE     = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD = 2'd2;
   localparam logic [1:0] CSR_COOLDOWN  = 2'd3;

   localparam logic [11:0] RANGE_RESET     = 12'd400;
   localparam logic [11:0] THRESHOLD_RESET = 12'd40;
   localparam logic [7:0]  COOLDOWN_RESET  = 8'd50;

   localparam logic signed [15:0] NO_ECHO = -16'sd1;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_CHECK
   } state_type;

   typedef struct packed {
      logic               rec_we;
      logic               save;
      logic               clear;
      logic [7:0]         deg;
      logic signed [15:0] echo;
      logic [11:0]        range;
      logic [11:0]        thr;
   } cell_ctrl_type;

   typedef struct packed {
      logic               found;
      logic [15:0]        best;
      logic [7:0]         angle;
      logic signed [15:0] hit;
      logic signed [15:0] base;
   } token_type;

   typedef struct packed {
      logic [7:0]         angle_deg;
      logic               detected;
      logic signed [15:0] hit_cm;
      logic signed [15:0] base_cm;
   } rsp_type;

endpackage

// ===== hw/rtl/ssid_cell.sv =====
// One sweep point: current and baseline distance plus one stage of the
// check token chain. Depends on ssid_pkg.
`timescale 1ns / 1ps

module ssid_cell import ssid_pkg::*; #(
   parameter int INDEX          = 0,
   parameter int POINTS         = POINTS_DEFAULT,
   parameter int SWEEP_MIN_DEG  = SWEEP_MIN_DEG_DEFAULT,
   parameter int SWEEP_STEP_DEG = SWEEP_STEP_DEG_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  token_type     tok_in,
   output token_type     tok_out
);

   localparam int         LO_DEG = SWEEP_MIN_DEG + INDEX * SWEEP_STEP_DEG;
   localparam int         HI_DEG = LO_DEG + SWEEP_STEP_DEG;
   localparam logic [7:0] ANGLE  = 8'(LO_DEG);

   logic signed [15:0] cur_ff, cur_in;
   logic signed [15:0] base_ff, base_in;
   token_type          tok_ff, tok_in_n;

   logic               match;
   logic signed [16:0] b_w, c_w, diff, range_w, thr_w;
   logic               new_echo, closer;
   logic [15:0]        d;

   always_comb begin
      if (INDEX == 0 && INDEX == POINTS - 1) begin
         match = 1'b1;
      end else if (INDEX == 0) begin
         match = 32'(ctrl.deg) < HI_DEG;
      end else if (INDEX == POINTS - 1) begin
         match = 32'(ctrl.deg) >= LO_DEG;
      end else begin
         match = (32'(ctrl.deg) >= LO_DEG) && (32'(ctrl.deg) < HI_DEG);
      end

      cur_in  = cur_ff;
      base_in = base_ff;
      if (ctrl.clear) begin
         cur_in = NO_ECHO;
      end else if (ctrl.rec_we && match) begin
         cur_in = ctrl.echo;
      end
      if (ctrl.save) begin
         base_in = cur_ff;
      end

      b_w      = 17'(base_ff);
      c_w      = 17'(cur_ff);
      range_w  = $signed({5'b0, ctrl.range});
      thr_w    = $signed({5'b0, ctrl.thr});
      diff     = b_w - c_w;
      new_echo = (b_w < 0) && (c_w > 0) && (c_w < range_w);
      closer   = (b_w > 0) && (c_w > 0) && (diff > thr_w);
      if (new_echo) begin
         d = 16'(range_w - c_w);
      end else begin
         d = diff[15:0];
      end

      tok_in_n = tok_in;
      if ((new_echo || closer) && (d > tok_in.best)) begin
         tok_in_n.found = 1'b1;
         tok_in_n.best  = d;
         tok_in_n.angle = ANGLE;
         tok_in_n.hit   = cur_ff;
         tok_in_n.base  = base_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= NO_ECHO;
         base_ff <= NO_ECHO;
      end else begin
         cur_ff  <= cur_in;
         base_ff <= base_in;
      end
      tok_ff <= tok_in_n;
   end

   assign tok_out = tok_ff;

endmodule

// ===== hw/rtl/ssid_out_queue.sv =====
// Two-word result queue that parts the response side from the command side.
// Depends on ssid_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sonar_sweep_intrusion_detector_macros.svh"

module ssid_out_queue import ssid_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    has_space,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   rsp_type    q0_ff, q0_in;
   rsp_type    q1_ff, q1_in;
   logic [1:0] count_ff, count_in;
   logic [1:0] count_pop;
   logic       pop;

   always_comb begin
      pop       = (count_ff != 2'd0) && out_ready;
      count_pop = count_ff - {1'b0, pop};
      q0_in     = pop ? q1_ff : q0_ff;
      q1_in     = q1_ff;
      if (push) begin
         if (count_pop == 2'd0) begin
            q0_in = push_data;
         end else begin
            q1_in = push_data;
         end
      end
      count_in = count_pop + {1'b0, push};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   assign has_space = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_data  = q0_ff;

   `SSID_ASSERT_SAME(a_no_overflow, clock, reset, push, (count_ff != 2'd2) || pop)
   `SSID_ASSERT_SAME(a_count_range, clock, reset, 1'b1, count_ff != 2'd3)

endmodule

// ===== hw/rtl/sonar_sweep_intrusion_detector.sv =====
// Top level of the sonar sweep intrusion detector: command decode, sweep
// position, cooldown and registers. Uses ssid_pkg, ssid_cell, ssid_out_queue.
//
//   channel  dir  handshake                payload
//   req      in   req_tvalid/req_tready    tuser func, tdata servo_deg, echo_cm
//   rsp      out  rsp_tvalid/rsp_tready    tuser detected, tdata angle, hit, base
//   csr      in   csr_we                   csr_index, csr_wdata
//
// Advance, record and save push their result word when accepted; a check that runs
// holds ST_CHECK while the token walks the cell chain, one cell per cycle. A refused
// check pushes its result word without entering ST_CHECK. A two-word result queue lets
// commands go on while results wait. Synchronous reset sets every stored distance to no echo.
// A full queue or a running check holds req_tready low.
`timescale 1ns / 1ps
`include "sonar_sweep_intrusion_detector_macros.svh"

module sonar_sweep_intrusion_detector import ssid_pkg::*; #(
   parameter int POINTS         = POINTS_DEFAULT,
   parameter int SWEEP_MIN_DEG  = SWEEP_MIN_DEG_DEFAULT,
   parameter int SWEEP_STEP_DEG = SWEEP_STEP_DEG_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,  // func
   input  logic [23:0] req_tdata,  // servo_deg[7:0], echo_cm[23:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tuser,  // detected
   output logic [39:0] rsp_tdata,  // angle_deg[7:0], hit_cm[23:8], base_cm[39:24]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   localparam int IW = $clog2(POINTS);

   state_type     state_ff, state_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] pos_ff, pos_in;
   logic          back_ff, back_in;
   logic [7:0]    cd_ff, cd_in;
   logic          bvalid_ff, bvalid_in;
   logic [1:0]    mode_ff, mode_in;
   logic [11:0]   range_ff, range_in;
   logic [11:0]   thr_ff, thr_in;
   logic [7:0]    cdt_ff, cdt_in;

   logic          accept, has_space, push;
   logic [1:0]    func, new_mode;
   rsp_type       push_data, out_data;
   cell_ctrl_type ctrl;
   token_type     tok [0:POINTS];

   assign req_tready = (state_ff == ST_IDLE) && has_space;
   assign accept     = req_tvalid && req_tready;
   assign func       = req_tuser;
   assign new_mode   = csr_wdata[1:0];

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pos_in    = pos_ff;
      back_in   = back_ff;
      cd_in     = cd_ff;
      bvalid_in = bvalid_ff;
      mode_in   = mode_ff;
      range_in  = range_ff;
      thr_in    = thr_ff;
      cdt_in    = cdt_ff;
      push      = 1'b0;
      push_data = '0;

      ctrl.rec_we  = 1'b0;
      ctrl.save    = 1'b0;
      ctrl.clear   = 1'b0;
      ctrl.deg     = req_tdata[7:0];
      ctrl.echo    = req_tdata[23:8];
      ctrl.range   = range_ff;
      ctrl.thr     = thr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (func)
                  FUNC_ADVANCE: begin
                     push                = 1'b1;
                     push_data.angle_deg = 8'(SWEEP_MIN_DEG) + 8'(pos_ff) * 8'(SWEEP_STEP_DEG);
                     if (back_ff) begin
                        if (pos_ff == '0) begin
                           back_in = 1'b0;
                        end else begin
                           pos_in = pos_ff - 1'b1;
                        end
                     end else begin
                        if (pos_ff == IW'(POINTS - 1)) begin
                           back_in = 1'b1;
                        end else begin
                           pos_in = pos_ff + 1'b1;
                        end
                     end
                  end
                  FUNC_RECORD: begin
                     push = 1'b1;
                     if (mode_ff != MODE_OFF) begin
                        ctrl.rec_we = 1'b1;
                        if (cd_ff != 8'd0) begin
                           cd_in = cd_ff - 8'd1;
                        end
                     end
                  end
                  FUNC_SAVE: begin
                     push      = 1'b1;
                     ctrl.save = 1'b1;
                     bvalid_in = 1'b1;
                  end
                  FUNC_CHECK: begin
                     if (!bvalid_ff || mode_ff != MODE_SENTINEL || cd_ff != 8'd0) begin
                        push = 1'b1;
                     end else begin
                        state_in = ST_CHECK;
                        cnt_in   = '0;
                     end
                  end
                  default: begin
                     push = 1'b1;
                  end
               endcase
            end
         end
         ST_CHECK: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IW'(POINTS - 1)) begin
               state_in            = ST_IDLE;
               push                = 1'b1;
               push_data.angle_deg = tok[POINTS].angle;
               push_data.detected  = tok[POINTS].found;
               push_data.hit_cm    = tok[POINTS].hit;
               push_data.base_cm   = tok[POINTS].base;
               if (tok[POINTS].found) begin
                  cd_in = cdt_ff;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         unique case (csr_index)
            CSR_MODE: begin
               if ((new_mode == MODE_OFF || new_mode == MODE_SCAN ||
                    new_mode == MODE_SENTINEL) && new_mode != mode_ff) begin
                  mode_in = new_mode;
                  if (new_mode == MODE_SCAN || new_mode == MODE_SENTINEL) begin
                     ctrl.clear = 1'b1;
                     pos_in     = '0;
                     back_in    = 1'b0;
                  end
               end
            end
            CSR_RANGE:     range_in = csr_wdata;
            CSR_THRESHOLD: thr_in   = csr_wdata;
            CSR_COOLDOWN:  cdt_in   = csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         pos_ff    <= '0;
         back_ff   <= 1'b0;
         cd_ff     <= 8'd0;
         bvalid_ff <= 1'b0;
         mode_ff   <= MODE_OFF;
         range_ff  <= RANGE_RESET;
         thr_ff    <= THRESHOLD_RESET;
         cdt_ff    <= COOLDOWN_RESET;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         pos_ff    <= pos_in;
         back_ff   <= back_in;
         cd_ff     <= cd_in;
         bvalid_ff <= bvalid_in;
         mode_ff   <= mode_in;
         range_ff  <= range_in;
         thr_ff    <= thr_in;
         cdt_ff    <= cdt_in;
      end
   end

   assign tok[0] = '0;

   for (genvar i = 0; i < POINTS; i++) begin : g_cell
      ssid_cell #(
         .INDEX          (i),
         .POINTS         (POINTS),
         .SWEEP_MIN_DEG  (SWEEP_MIN_DEG),
         .SWEEP_STEP_DEG (SWEEP_STEP_DEG)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .tok_in  (tok[i]),
         .tok_out (tok[i+1])
      );
   end

   ssid_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .has_space (has_space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tuser = out_data.detected;
   assign rsp_tdata = {out_data.base_cm, out_data.hit_cm, out_data.angle_deg};

   `SSID_ASSERT_SAME(a_busy_blocks, clock, reset, state_ff == ST_CHECK, !req_tready)
   `SSID_ASSERT_NEXT(a_check_runs, clock, reset,
      state_ff == ST_CHECK && cnt_ff != IW'(POINTS - 1), state_ff == ST_CHECK)
   `SSID_ASSERT_NEXT(a_advance_result, clock, reset,
      accept && func == FUNC_ADVANCE, rsp_tvalid)
   `SSID_ASSERT_NEXT(a_cooldown_count, clock, reset,
      accept && func == FUNC_RECORD && mode_ff != MODE_OFF && cd_ff != 8'd0,
      cd_ff == $past(cd_ff) - 8'd1)

endmodule

// ===== tb/sonar_sweep_intrusion_detector_test.sv =====
// Self-checking testbench for sonar_sweep_intrusion_detector: directed and random
// command words against an in-bench model of the sweep store and alert search.
// Depends on ssid_pkg and the detector RTL only.
`timescale 1ns / 1ps

module sonar_sweep_intrusion_detector_test;
   import ssid_pkg::*;

   localparam int PTS         = POINTS_DEFAULT;
   localparam int SWEEP_LO    = SWEEP_MIN_DEG_DEFAULT;
   localparam int SWEEP_STEP  = SWEEP_STEP_DEG_DEFAULT;
   localparam int SWEEP_HI    = SWEEP_LO + (PTS - 1) * SWEEP_STEP;
   localparam int QUIET_LIMIT = 4000;
   localparam int RANDOM_WORDS = 1650;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser  = '0;  // func
   logic [23:0] req_tdata  = '0;  // servo_deg[7:0], echo_cm[23:8]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        rsp_tuser;        // detected
   logic [39:0] rsp_tdata;        // angle_deg[7:0], hit_cm[23:8], base_cm[39:24]
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [11:0] csr_wdata  = '0;

   sonar_sweep_intrusion_detector u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // model of the detector state
   logic [1:0]         mode_reg;
   logic [11:0]        range_reg;
   logic [11:0]        thr_reg;
   logic [7:0]         cool_ticks_reg;
   logic signed [15:0] live_cm [PTS];
   logic signed [15:0] saved_cm [PTS];
   bit                 base_ok;
   int                 sweep_pos;
   bit                 sweep_down;
   logic [7:0]         cool_left;

   rsp_type expected_rsp [$];

   int error_count   = 0;
   int checked_count = 0;
   int item_count    = 0;
   int alert_count   = 0;
   int reg_writes    = 0;
   int setup_count   = 0;
   int func_count [4] = '{0, 0, 0, 0};
   int quiet_cycles  = 0;
   int burst_left    = 8;
   bit gap_free      = 1'b0;

   logic [7:0] stall_count = '0;
   int         stall_style = 0;

   function automatic void reset_model();
      mode_reg       = MODE_OFF;
      range_reg      = RANGE_RESET;
      thr_reg        = THRESHOLD_RESET;
      cool_ticks_reg = COOLDOWN_RESET;
      foreach (live_cm[i]) live_cm[i] = NO_ECHO;
      foreach (saved_cm[i]) saved_cm[i] = NO_ECHO;
      base_ok    = 1'b0;
      sweep_pos  = 0;
      sweep_down = 1'b0;
      cool_left  = '0;
   endfunction

   function automatic logic [7:0] sweep_angle(int p);
      return 8'(SWEEP_LO + p * SWEEP_STEP);
   endfunction

   function automatic int sweep_index(logic [7:0] deg);
      int a;
      a = int'(deg);
      if (a < SWEEP_LO) return 0;
      if (a > SWEEP_HI) return PTS - 1;
      return (a - SWEEP_LO) / SWEEP_STEP;
   endfunction

   function automatic void apply_reg(logic [1:0] index, logic [11:0] value);
      logic [1:0] m;
      m = value[1:0];
      case (index)
         CSR_MODE: begin
            if (m != mode_reg && (m == MODE_OFF || m == MODE_SCAN || m == MODE_SENTINEL)) begin
               mode_reg = m;
               if (m != MODE_OFF) begin
                  sweep_pos  = 0;
                  sweep_down = 1'b0;
                  foreach (live_cm[i]) live_cm[i] = NO_ECHO;
               end
            end
         end
         CSR_RANGE:     range_reg = value;
         CSR_THRESHOLD: thr_reg = value;
         default:       cool_ticks_reg = value[7:0];
      endcase
   endfunction

   function automatic rsp_type predict_detector(logic [1:0] func, logic [7:0] deg,
                                                logic signed [15:0] echo);
      rsp_type word;
      int best, spot, gain, b, c, rng, thr;
      word = '0;
      case (func)
         FUNC_ADVANCE: begin
            word.angle_deg = sweep_angle(sweep_pos);
            if (sweep_down) sweep_pos--;
            else sweep_pos++;
            if (sweep_pos >= PTS) begin
               sweep_pos  = PTS - 1;
               sweep_down = 1'b1;
            end else if (sweep_pos < 0) begin
               sweep_pos  = 0;
               sweep_down = 1'b0;
            end
         end
         FUNC_RECORD: begin
            if (mode_reg != MODE_OFF) begin
               live_cm[sweep_index(deg)] = echo;
               if (cool_left != 0) cool_left--;
            end
         end
         FUNC_SAVE: begin
            saved_cm = live_cm;
            base_ok  = 1'b1;
         end
         default: begin
            if (base_ok && mode_reg == MODE_SENTINEL && cool_left == 0) begin
               best = 0;
               spot = -1;
               rng  = int'(range_reg);
               thr  = int'(thr_reg);
               for (int i = 0; i < PTS; i++) begin
                  b = saved_cm[i];
                  c = live_cm[i];
                  gain = -1;
                  if (b < 0 && c > 0 && c < rng) gain = rng - c;
                  else if (b > 0 && c > 0 && (b - c) > thr) gain = b - c;
                  if (gain > best) begin
                     best = gain;
                     spot = i;
                  end
               end
               if (spot >= 0) begin
                  word.angle_deg = sweep_angle(spot);
                  word.detected  = 1'b1;
                  word.hit_cm    = live_cm[spot];
                  word.base_cm   = saved_cm[spot];
                  cool_left      = cool_ticks_reg;
                  alert_count++;
               end
            end
         end
      endcase
      return word;
   endfunction

   task automatic report_mismatch(string what, longint want, longint got);
      $display("mismatch at result %0d: %s expected %0d got %0d",
               checked_count, what, want, got);
      error_count++;
   endtask

   task automatic send_word(logic [1:0] func, logic [7:0] deg, logic signed [15:0] echo);
      rsp_type word;
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {echo, deg};
      do @(posedge clock); while (!req_tready);
      word = predict_detector(func, deg, echo);
      expected_rsp.push_back(word);
      item_count++;
      func_count[func]++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         if (!gap_free) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [11:0] value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      apply_reg(index, value);
      reg_writes++;
   endtask

   function automatic logic [7:0] pick_deg();
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(SWEEP_LO, SWEEP_HI));
   endfunction

   function automatic logic signed [15:0] pick_echo();
      case ($urandom_range(0, 19))
         0, 1:    return 16'($urandom) | 16'h8000;
         2, 3:    return 16'($urandom);
         4:       return 16'sh7FFF;
         5:       return 16'sh8000;
         6:       return 16'sh0000;
         7:       return 16'shFFFF;
         default: return 16'($urandom_range(1, 500));
      endcase
   endfunction

   // servo loop: step the sweep and record at the angle it reports
   task automatic sweep_pass();
      int n;
      logic [7:0] a;
      n = $urandom_range(40, 140);
      repeat (n) begin
         a = sweep_angle(sweep_pos);
         send_word(FUNC_ADVANCE, 8'($urandom), 16'($urandom));
         send_word(FUNC_RECORD, a, pick_echo());
      end
   endtask

   task automatic run_sequence();
      int n;
      if ($urandom_range(0, 4) == 0) begin
         sweep_pass();
      end else begin
         n = $urandom_range(3, 24);
         repeat (n) begin
            if ($urandom_range(0, 5) == 0) send_word(FUNC_ADVANCE, 8'($urandom), 16'($urandom));
            else send_word(FUNC_RECORD, pick_deg(), pick_echo());
         end
      end
      if ($urandom_range(0, 2) != 0) send_word(FUNC_SAVE, 8'($urandom), 16'($urandom));
      n = $urandom_range(0, 5);
      repeat (n) send_word(FUNC_RECORD, pick_deg(), 16'($urandom_range(1, 300)));
      n = $urandom_range(1, 2);
      repeat (n) send_word(FUNC_CHECK, 8'($urandom), 16'($urandom));
      n = $urandom_range(0, 3);
      repeat (n) send_word(2'($urandom), 8'($urandom), 16'($urandom));
   endtask

   task automatic pick_random_setup();
      logic [1:0]  m;
      logic [11:0] v;
      case ($urandom_range(0, 9))
         0:       m = MODE_OFF;
         1:       m = MODE_SCAN;
         2:       m = MODE_UNUSED;
         default: m = MODE_SENTINEL;
      endcase
      write_reg(CSR_MODE, (12'($urandom) & 12'hFFC) | 12'(m));
      case ($urandom_range(0, 5))
         0:       v = 12'd1;
         1:       v = 12'd4095;
         default: v = 12'($urandom_range(50, 1000));
      endcase
      write_reg(CSR_RANGE, v);
      case ($urandom_range(0, 5))
         0:       v = 12'd0;
         1:       v = 12'd4095;
         default: v = 12'($urandom_range(0, 200));
      endcase
      write_reg(CSR_THRESHOLD, v);
      case ($urandom_range(0, 9))
         0:       v = 12'd0;
         1:       v = 12'd255;
         default: v = 12'($urandom_range(0, 6));
      endcase
      write_reg(CSR_COOLDOWN, (12'($urandom) & 12'hF00) | v);
      setup_count++;
   endtask

   // reset state: off mode, no baseline
   task automatic test_refused_checks();
      send_word(FUNC_ADVANCE, 8'd0, 16'sd0);
      send_word(FUNC_RECORD, 8'd40, 16'sd100);
      write_reg(CSR_MODE, 12'(MODE_SENTINEL));
      send_word(FUNC_CHECK, 8'hFF, 16'shFFFF);
      write_reg(CSR_MODE, 12'(MODE_OFF));
      send_word(FUNC_SAVE, 8'd0, 16'sd0);
      send_word(FUNC_CHECK, 8'd0, 16'sd0);
   endtask

   task automatic test_clamp_and_alerts();
      write_reg(CSR_MODE, 12'(MODE_UNUSED));
      write_reg(CSR_MODE, 12'(MODE_OFF));
      write_reg(CSR_COOLDOWN, 12'd0);
      write_reg(CSR_MODE, 12'(MODE_SENTINEL));
      send_word(FUNC_ADVANCE, 8'd255, 16'sh7FFF);
      send_word(FUNC_RECORD, 8'd0, 16'sd100);
      send_word(FUNC_RECORD, 8'd255, 16'sh7FFF);
      send_word(FUNC_RECORD, 8'd29, 16'sh8000);
      send_word(FUNC_RECORD, 8'd80, 16'sd0);
      send_word(FUNC_CHECK, 8'd0, 16'sd0);
      write_reg(CSR_MODE, 12'(MODE_SENTINEL));
      send_word(FUNC_CHECK, 8'd0, 16'sd0);
   endtask

   // equal strengths at two points, then cooldown countdown by records
   task automatic test_cooldown();
      write_reg(CSR_COOLDOWN, 12'hA02);
      send_word(FUNC_RECORD, 8'd60, 16'sd100);
      send_word(FUNC_CHECK, 8'd0, 16'sd0);
      send_word(FUNC_CHECK, 8'd0, 16'sd0);
      send_word(FUNC_RECORD, 8'd152, 16'sd399);
      send_word(FUNC_RECORD, 8'd153, 16'sd1);
      send_word(FUNC_CHECK, 8'd0, 16'sd0);
   endtask

   task automatic test_closer_echo_and_limits();
      write_reg(CSR_COOLDOWN, 12'd0);
      write_reg(CSR_THRESHOLD, 12'd0);
      write_reg(CSR_RANGE, 12'd4095);
      send_word(FUNC_SAVE, 8'd0, 16'sd0);
      send_word(FUNC_RECORD, 8'd26, 16'sd99);
      send_word(FUNC_RECORD, 8'd200, 16'sd5);
      send_word(FUNC_CHECK, 8'd0, 16'sd0);
      write_reg(CSR_THRESHOLD, 12'd4095);
      write_reg(CSR_RANGE, 12'd1);
      send_word(FUNC_CHECK, 8'd0, 16'sd0);
      write_reg(CSR_MODE, 12'(MODE_SCAN));
      send_word(FUNC_RECORD, 8'd100, 16'sd50);
      send_word(FUNC_CHECK, 8'd0, 16'sd0);
      send_word(FUNC_ADVANCE, 8'd0, 16'sd0);
   endtask

   task automatic test_random_traffic(int goal);
      int stop_at, phase_end;
      stop_at = item_count + goal;
      while (item_count < stop_at) begin
         pick_random_setup();
         gap_free  = ($urandom_range(0, 3) == 0);
         phase_end = item_count + $urandom_range(150, 350);
         while (item_count < phase_end && item_count < stop_at) run_sequence();
      end
      gap_free = 1'b0;
   endtask

   always @(posedge clock) begin
      stall_count <= stall_count + 8'd1;
      if (stall_count == 0) stall_style <= $urandom_range(0, 3);
      case (stall_style)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= ($urandom_range(0, 4) == 0);
         default: rsp_tready <= (stall_count[3:1] != 3'b101);
      endcase
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("word with nothing pending, tdata", 0, longint'(rsp_tdata));
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_tdata[7:0] !== want.angle_deg)
               report_mismatch("angle_deg", want.angle_deg, rsp_tdata[7:0]);
            if (rsp_tuser !== want.detected)
               report_mismatch("detected", want.detected, rsp_tuser);
            if (rsp_tdata[23:8] !== want.hit_cm)
               report_mismatch("hit_cm", want.hit_cm, $signed(rsp_tdata[23:8]));
            if (rsp_tdata[39:24] !== want.base_cm)
               report_mismatch("base_cm", want.base_cm, $signed(rsp_tdata[39:24]));
         end
         checked_count++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results pending",
                  QUIET_LIMIT, expected_rsp.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      reset_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_refused_checks();
      test_clamp_and_alerts();
      test_cooldown();
      test_closer_echo_and_limits();
      test_random_traffic(RANDOM_WORDS);
      wait_idle();
      repeat (PTS + 8) @(posedge clock);
      if (expected_rsp.size() != 0)
         report_mismatch("results never delivered, count", 0, expected_rsp.size());
      $display("covered %0d words: %0d advance, %0d record, %0d save, %0d check; %0d alerts",
               item_count, func_count[FUNC_ADVANCE], func_count[FUNC_RECORD],
               func_count[FUNC_SAVE], func_count[FUNC_CHECK], alert_count);
      $display("%0d register writes across %0d random setups, %0d results compared",
               reg_writes, setup_count, checked_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
